/* rtl/wtpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtpa_pkg
// Shared types and constants of the wildcard time-pattern alarm unit.
// ----------------------------------------------------------------------------
package wtpa_pkg;

    localparam int ENTRIES_DEFAULT = 32;
    localparam int MASK_W          = 32;
    localparam int NF              = 5;
    localparam int TUP_W           = 31;
    localparam int EXT_W           = 8;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef logic [TUP_W-1:0]           tup_t;
    typedef logic [NF-1:0][EXT_W-1:0]   ext_t;

    typedef struct packed
    {
        cmd_t kind;
        tup_t tup;
    } item_t;

    typedef struct packed
    {
        logic  valid;
        item_t item;
    } head_t;

    // month, day, hour, minute, second, each sign-extended to EXT_W bits
    function automatic ext_t widen(input tup_t t);
        ext_t r;
        r[0] = {{(EXT_W-5){t[4]}},  t[4:0]};
        r[1] = {{(EXT_W-6){t[10]}}, t[10:5]};
        r[2] = {{(EXT_W-6){t[16]}}, t[16:11]};
        r[3] = {{(EXT_W-7){t[23]}}, t[23:17]};
        r[4] = {{(EXT_W-7){t[30]}}, t[30:24]};
        return r;
    endfunction

endpackage

/* rtl/wtpa_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtpa_front
// Accepts input beats, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module wtpa_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // month, day, hour, minute, second, pad
    input  logic                 s_tuser,   // cmd
    output wtpa_pkg::head_t      head,
    input  logic                 pop
);
    import wtpa_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       do_pop;
    item_t      in_item;

    assign s_tready     = (cnt_reg != 2'd2);
    assign push         = s_tvalid && s_tready;
    assign do_pop       = pop && (cnt_reg != 2'd0);
    assign in_item.kind = cmd_t'(s_tuser);
    assign in_item.tup  = s_tdata[TUP_W-1:0];
    assign head.valid   = (cnt_reg != 2'd0);
    assign head.item    = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/wtpa_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtpa_back
// Executes queued commands: table loads and ticks that walk the pattern table.
// ----------------------------------------------------------------------------
module wtpa_back
#(
    parameter int ENTRIES = wtpa_pkg::ENTRIES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wtpa_pkg::head_t      head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // due_mask
    output logic [1:0]           m_tuser    // table_full, primed_only
);
    import wtpa_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    tup_t              mem [ENTRIES];
    tup_t              rdata_reg;
    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              primed_reg, primed_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              full_reg, full_next;
    logic              ponly_reg, ponly_next;
    tup_t              prev_reg;
    logic              out_valid_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic [1:0]        out_flags_reg;
    logic              out_free;
    logic              wr_en;
    logic              due;

    ext_t              p, v, c, a, b;
    logic [NF-1:0]     wild;
    logic              lt, dn, found;
    logic [2:0]        d, k;

    function automatic logic earlier(input ext_t x, input ext_t y);
        logic r, f;
        r = 1'b0;
        f = 1'b0;
        for (int i = 0; i < NF; i++)
        begin
            if (!f && ($signed(x[i]) < $signed(y[i])))
            begin
                r = 1'b1;
                f = 1'b1;
            end
            else if (!f && ($signed(x[i]) > $signed(y[i])))
            begin
                f = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        p  = widen(rdata_reg);
        v  = widen(prev_reg);
        c  = widen(head.item.tup);
        lt = 1'b0;
        dn = 1'b0;
        d  = 3'(NF);
        for (int i = 0; i < NF; i++)
        begin
            wild[i] = (p[i] == {EXT_W{1'b1}});
            a[i]    = wild[i] ? v[i] : p[i];
        end
        for (int i = 0; i < NF; i++)
        begin
            if (!dn && ($signed(a[i]) < $signed(v[i])))
            begin
                lt = 1'b1;
                dn = 1'b1;
                d  = 3'(i);
            end
            else if (!dn && ($signed(a[i]) > $signed(v[i])))
            begin
                dn = 1'b1;
            end
        end
        found = 1'b0;
        k     = 3'd0;
        for (int i = 0; i < NF; i++)
        begin
            if ((3'(i) < d) && wild[i])
            begin
                found = 1'b1;
                k     = 3'(i);
            end
        end
        for (int i = 0; i < NF; i++)
        begin
            if (3'(i) < k)
                b[i] = a[i];
            else if (3'(i) == k)
                b[i] = v[i] + EXT_W'(1);
            else
                b[i] = wild[i] ? '0 : p[i];
        end
        due = lt ? (found && earlier(b, c)) : earlier(a, c);
    end

    assign out_free = !out_valid_reg || m_tready;
    assign wr_en    = (state_reg == S_IDLE) && head.valid && (head.item.kind == CMD_LOAD)
                      && (count_reg < CW'(ENTRIES));
    assign pop      = (state_reg == S_DONE) && out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;
    assign m_tuser  = out_flags_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        primed_next = primed_reg;
        mask_next   = mask_reg;
        full_next   = full_reg;
        ponly_next  = ponly_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    mask_next  = '0;
                    full_next  = 1'b0;
                    ponly_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_DONE;
                    if (head.item.kind == CMD_LOAD)
                    begin
                        if (wr_en)
                            count_next = count_reg + CW'(1);
                        else
                            full_next = 1'b1;
                    end
                    else if (!primed_reg)
                    begin
                        primed_next = 1'b1;
                        ponly_next  = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                mask_next[idx_reg] = due;
                idx_next           = idx_reg + IW'(1);
                if (CW'(idx_reg) + CW'(1) == count_reg)
                    state_next = S_DONE;
                else
                    state_next = S_READ;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IW-1:0]] <= head.item.tup;
        end
        rdata_reg <= mem[idx_reg];
        if (pop && (head.item.kind == CMD_TICK))
        begin
            prev_reg <= head.item.tup;
        end
        if (pop)
        begin
            out_mask_reg  <= mask_reg;
            out_flags_reg <= {ponly_reg, full_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            primed_reg    <= 1'b0;
            mask_reg      <= '0;
            full_reg      <= 1'b0;
            ponly_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            primed_reg <= primed_next;
            mask_reg   <= mask_next;
            full_reg   <= full_next;
            ponly_reg  <= ponly_next;
            if (pop)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/wildcard_time_pattern_alarm_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_time_pattern_alarm_unit
// Alarm pattern table with wildcard fields, checked against each time tick.
// ----------------------------------------------------------------------------
// Input stream: s_tuser is the command (0 load pattern, 1 time tick), s_tdata
// carries month, day, hour, minute, second. Every input beat yields exactly
// one output beat: m_tdata is the due mask, m_tuser flags a dropped load
// (bit 0) or a first tick that only stored the time (bit 1).
// A two-deep queue sits in front of the executing engine, so inputs are
// taken while a result waits on a stalled receiver.
// Loads and the first tick go from the queue head to the done state and then
// to the output register. A later tick walks the N stored patterns through
// the shared evaluator, with a table read and an evaluate state per pattern.
// Reset empties the queue and the table count and clears the primed flag;
// table contents and previous time are not cleared. While m_tready is low
// the result holds and the engine waits, the queue keeps accepting until
// full.
// ----------------------------------------------------------------------------
module wildcard_time_pattern_alarm_unit
#(
    parameter int ENTRIES = wtpa_pkg::ENTRIES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // month[4:0], day[10:5], hour[16:11],
                                   // minute[23:17], second[30:24], pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // due_mask
    output logic [1:0]  m_tuser    // table_full, primed_only
);
    import wtpa_pkg::*;

    head_t head;
    logic  pop;

    wtpa_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    wtpa_back #(.ENTRIES(ENTRIES)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("table_full and primed_only both set");

    a_flag_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != 2'b00)) |-> (m_tdata == '0))
        else $error("flagged beat carries a due mask");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("engine finished with an empty queue");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the wildcard time-pattern alarm unit: directed and
// random loads and ticks are driven in bursts, while a behavioral alarm
// evaluator predicts each output beat and the monitor compares it.
// ----------------------------------------------------------------------------
module tb_top;

    import wtpa_pkg::*;

    localparam int N_ENT = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed
    {
        logic [31:0] due;
        logic        full;
        logic        primed;
    } alarm_res_t;

    typedef struct packed
    {
        cmd_t        kind;
        logic [30:0] tup;
    } stim_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    wildcard_time_pattern_alarm_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    stim_t      pending_q[$];
    alarm_res_t expected_q[$];
    int         pat_tab[N_ENT][5];
    int         pat_count;
    int         prev_t[5];
    bit         primed;
    int         errors;
    int         idle_cycles;
    bit         hold_off;
    int         burst_left;
    int         gap_left;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic void split_tup(input logic [30:0] t, output int f[5]);
        f[0] = $signed(t[4:0]);
        f[1] = $signed(t[10:5]);
        f[2] = $signed(t[16:11]);
        f[3] = $signed(t[23:17]);
        f[4] = $signed(t[30:24]);
    endfunction

    function automatic bit tup_lt(input int a[5], input int b[5]);
        for (int k = 0; k < 5; k++)
        begin
            if (a[k] < b[k]) return 1'b1;
            if (a[k] > b[k]) return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic int wild_to_left(input int p[5], input int from);
        for (int k = from - 1; k >= 0; k--)
            if (p[k] == -1) return k;
        return -1;
    endfunction

    function automatic bit alarm_due(input int p[5], input int pv[5], input int cur[5]);
        int a[5];
        int k;
        for (k = 0; k < 5; k++)
            a[k] = (p[k] == -1) ? pv[k] : p[k];
        if (tup_lt(a, pv))
        begin
            k = wild_to_left(p, 5);
            if (k < 0) return 1'b0;
            forever
            begin
                a[k] += 1;
                if (tup_lt(pv, a)) break;
                a[k] = 0;
                k = wild_to_left(p, k);
                if (k < 0) return 1'b0;
            end
        end
        return tup_lt(a, cur);
    endfunction

    function automatic alarm_res_t predict_alarm(input stim_t s);
        alarm_res_t r;
        int t[5];
        r = '0;
        split_tup(s.tup, t);
        if (s.kind == CMD_LOAD)
        begin
            if (pat_count >= N_ENT)
                r.full = 1'b1;
            else
            begin
                pat_tab[pat_count] = t;
                pat_count++;
            end
        end
        else if (!primed)
        begin
            prev_t = t;
            primed = 1'b1;
            r.primed = 1'b1;
        end
        else
        begin
            for (int e = 0; e < pat_count; e++)
                if (alarm_due(pat_tab[e], prev_t, t)) r.due[e] = 1'b1;
            prev_t = t;
        end
        return r;
    endfunction

    function automatic logic [30:0] pack_tup(input int f[5]);
        return {f[4][6:0], f[3][6:0], f[2][5:0], f[1][5:0], f[0][4:0]};
    endfunction

    // mostly wildcards and in-range values, sometimes raw bits
    function automatic int pick_field(input int hi, input int w);
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return -1;
        if (r < 9) return $urandom_range(0, hi);
        return $urandom_range(0, (1 << w) - 1);
    endfunction

    task automatic push_item(input cmd_t kind, input int f[5]);
        stim_t s;
        s.kind = kind;
        s.tup = pack_tup(f);
        pending_q.push_back(s);
    endtask

    initial
    begin
        int f[5];
        int cur[5];
        int hi[5];
        int wd[5];
        hi = '{12, 31, 23, 59, 59};
        wd = '{5, 6, 6, 7, 7};
        // directed: first tick, wildcard patterns, out-of-range raw bits
        f = '{1, 1, 0, 0, 0};            push_item(CMD_TICK, f);
        f = '{-1, -1, -1, -1, -1};       push_item(CMD_LOAD, f);
        f = '{-1, -1, -1, -1, 30};       push_item(CMD_LOAD, f);
        f = '{12, 31, 23, 59, 59};       push_item(CMD_LOAD, f);
        f = '{1, 1, 0, 0, 0};            push_item(CMD_LOAD, f);
        f = '{-16, -32, -32, -64, -64};  push_item(CMD_LOAD, f);
        f = '{15, 31, 31, 63, 63};       push_item(CMD_LOAD, f);
        f = '{-1, 5, -1, 0, -1};         push_item(CMD_LOAD, f);
        f = '{1, 1, 0, 0, 40};           push_item(CMD_TICK, f);
        f = '{1, 1, 0, 1, 0};            push_item(CMD_TICK, f);
        f = '{12, 31, 23, 59, 59};       push_item(CMD_TICK, f);
        f = '{1, 1, 0, 0, 0};            push_item(CMD_TICK, f);
        f = '{-16, -32, -32, -64, -64};  push_item(CMD_TICK, f);
        f = '{15, 31, 31, 63, 63};       push_item(CMD_TICK, f);
        // fill the table, then overflow it
        for (int i = 0; i < 27; i++)
        begin
            for (int k = 0; k < 5; k++) f[k] = pick_field(hi[k], wd[k]);
            push_item(CMD_LOAD, f);
        end
        f = '{-1, -1, -1, -1, -1};       push_item(CMD_LOAD, f);
        for (int k = 0; k < 5; k++) cur[k] = (k < 2) ? 1 : 0;
        push_item(CMD_TICK, cur);
        // random ticks that mostly advance a plausible clock, some noise ticks and loads
        for (int i = 0; i < 1800; i++)
        begin
            int r;
            r = $urandom_range(0, 19);
            if (r == 0)
            begin
                for (int k = 0; k < 5; k++) f[k] = pick_field(hi[k], wd[k]);
                push_item(CMD_LOAD, f);
            end
            else if (r == 1)
            begin
                for (int k = 0; k < 5; k++)
                    f[k] = $signed($urandom_range(0, (1 << wd[k]) - 1) << (32 - wd[k]))
                           >>> (32 - wd[k]);
                push_item(CMD_TICK, f);
            end
            else
            begin
                int k;
                k = $urandom_range(0, 4);
                cur[k] += $urandom_range(1, 30);
                if (cur[k] > hi[k])
                begin
                    cur[k] = (k < 2) ? 1 : 0;
                end
                for (int j = k + 1; j < 5; j++)
                    if ($urandom_range(0, 1)) cur[j] = $urandom_range(0, hi[j]);
                push_item(CMD_TICK, cur);
            end
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                expected_q.push_back(predict_alarm(stim_t'{cmd_t'(s_tuser), s_tdata[30:0]}));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                stim_t s;
                s = pending_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, s.tup};
                s_tuser  <= s.kind;
                if (burst_left <= 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected beat: actual due=%h user=%b", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                alarm_res_t x;
                x = expected_q.pop_front();
                if (m_tdata !== x.due)
                begin
                    $display("%0t due_mask: expected %h actual %h", $time, x.due, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== x.full)
                begin
                    $display("%0t table_full: expected %b actual %b", $time, x.full, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== x.primed)
                begin
                    $display("%0t primed_only: expected %b actual %b", $time, x.primed,
                             m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        pat_count = 0;
        primed = 1'b0;
        prev_t = '{0, 0, 0, 0, 0};
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        idle_cycles = 0;
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
